// File: src/isl_pkg.sv
`default_nettype none
package isl_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic [2:0] op_t;
  localparam op_t OP_APPEND = 3'd0;
  localparam op_t OP_INSERT = 3'd1;
  localparam op_t OP_REMOVE = 3'd2;
  localparam op_t OP_SET    = 3'd3;
  localparam op_t OP_GET    = 3'd4;
  localparam op_t OP_FIND   = 3'd5;
  localparam op_t OP_CLEAR  = 3'd6;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_INDEX = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  // broadcast to every cell in the row
  typedef struct packed {
    logic                  upd;
    op_t                   op;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] word;
  } cmd_t;

endpackage
`default_nettype wire

// File: src/isl_cell.sv
`default_nettype none
module isl_cell (
  input  wire logic                          clk,
  input  wire logic [isl_pkg::CNT_W-1:0]     idx,
  input  wire isl_pkg::cmd_t                 cmd,
  input  wire logic [isl_pkg::DATA_WIDTH-1:0] left_data,
  input  wire logic [isl_pkg::DATA_WIDTH-1:0] right_data,
  output logic      [isl_pkg::DATA_WIDTH-1:0] data,
  output logic                               hit
);
  import isl_pkg::*;

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.op)
      OP_APPEND: begin
        if (idx == cmd.count) data_next = cmd.word;
      end
      OP_INSERT: begin
        if (idx == cmd.pos) data_next = cmd.word;
        else if (idx > cmd.pos) data_next = left_data;
      end
      OP_REMOVE: begin
        if (idx >= cmd.pos) data_next = right_data;
      end
      OP_SET: begin
        if (idx == cmd.pos) data_next = cmd.word;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) data <= data_next;
  end

  always_comb begin
    case (cmd.op)
      OP_GET:  hit = (idx == cmd.pos);
      OP_FIND: hit = (idx < cmd.count) && (data == cmd.word);
      default: hit = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/indexed_shift_list_unit.sv
`default_nettype none
// an accepted word is registered in S_IDLE, and its result in S_RESOLVE
// one word at a time: the single output register holds off the next word
//   until its result is taken
// all entries shift or compare in parallel in the row of cells
// reset: entry count goes to zero, no result pending; entry storage is not cleared
module indexed_shift_list_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire isl_pkg::op_t                    op,
  input  wire logic [isl_pkg::CNT_W-1:0]       position,
  input  wire logic [31:0]                     value_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output isl_pkg::status_t                     status,
  output logic [31:0]                          value_out,
  output logic [isl_pkg::IDX_W-1:0]            found_index,
  output logic [isl_pkg::CNT_W-1:0]            entry_count,
  output logic                                 is_empty
);
  import isl_pkg::*;

  typedef enum logic {S_IDLE, S_RESOLVE} state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  status_t               status_next;
  op_t                   op_q;
  status_t               status_q;
  logic [CAPACITY-1:0]   hits;
  logic [CAPACITY-1:0]   hit_w;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic                  accept;
  logic                  modify;
  cmd_t                  cmd;
  logic [DATA_WIDTH-1:0] read_word;
  logic [IDX_W-1:0]      first_hit;
  logic                  any_hit;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;

  // status and new count, from the list as it stands before the word
  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    case (op)
      OP_APPEND: begin
        if (count >= CNT_W'(CAPACITY)) status_next = ST_FULL;
        else count_next = count + 1'b1;
      end
      OP_INSERT: begin
        if (position > count) status_next = ST_BAD_INDEX;
        else if (count >= CNT_W'(CAPACITY)) status_next = ST_FULL;
        else count_next = count + 1'b1;
      end
      OP_REMOVE: begin
        if (position >= count) status_next = ST_BAD_INDEX;
        else count_next = count - 1'b1;
      end
      OP_SET, OP_GET: begin
        if (position >= count) status_next = ST_BAD_INDEX;
      end
      OP_CLEAR: count_next = '0;
      default: status_next = ST_OK;
    endcase
  end

  assign modify = accept && (status_next == ST_OK) &&
                  (op inside {OP_APPEND, OP_INSERT, OP_REMOVE, OP_SET});

  assign cmd.upd   = modify;
  assign cmd.op    = op;
  assign cmd.pos   = position;
  assign cmd.count = count;
  assign cmd.word  = value_in[DATA_WIDTH-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    isl_cell u_cell (
      .clk        (clk),
      .idx        (CNT_W'(i)),
      .cmd        (cmd),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i]),
      .hit        (hit_w[i])
    );
  end

  // and-or read of the selected cell, and lowest matching index
  always_comb begin
    read_word = '0;
    first_hit = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hits[i]) read_word = read_word | cell_data[i];
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) first_hit = IDX_W'(i);
    end
  end
  assign any_hit = |hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_RESOLVE;
            count    <= count_next;
            op_q     <= op;
            status_q <= status_next;
            hits     <= (status_next == ST_OK) ? hit_w : '0;
          end
        end
        S_RESOLVE: begin
          state       <= S_IDLE;
          out_valid   <= 1'b1;
          entry_count <= count;
          is_empty    <= (count == '0);
          value_out   <= (op_q == OP_GET) ? 32'(read_word) : '0;
          found_index <= (op_q == OP_FIND) ? first_hit : '0;
          if (op_q == OP_FIND && !any_hit) status <= ST_NOT_FOUND;
          else status <= status_q;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
